// File: rtl/svg_pkg.sv
package svg_pkg;

  localparam int MAX_COUNT       = 255;
  localparam int TRIG_ITERATIONS = 16;
  localparam int IDX_W           = 8;
  localparam int CNT_W           = $clog2(MAX_COUNT + 1);
  localparam int NUM_W           = CNT_W + 16;
  localparam int QUO_W           = 17;
  localparam int PH_W            = 16;
  localparam int CORD_W          = 34;
  localparam int Q14_W           = 16;
  localparam int CORDIC_LAT      = TRIG_ITERATIONS + 2;
  localparam int ADDR_W          = 4;
  localparam int QUEUE_DEPTH     = 4;
  localparam logic [31:0] CORDIC_START = 32'h26DD3B6A;

  typedef enum logic [1:0] {
    REG_RADIUS  = 2'd0,
    REG_SECTORS = 2'd1,
    REG_STACKS  = 2'd2
  } reg_idx_e;

  // one classified request waiting for the arithmetic pipeline
  typedef struct packed {
    logic [IDX_W-1:0] stk;
    logic [IDX_W-1:0] sec;
    logic [CNT_W-1:0] n;
    logic [CNT_W-1:0] m;
    logic             oor;
  } req_t;

  function automatic logic [31:0] atan_lut(input int unsigned i);
    logic [31:0] v;
    case (i)
      0:  v = 32'h20000000;
      1:  v = 32'h12E4051E;
      2:  v = 32'h09FB385B;
      3:  v = 32'h051111D4;
      4:  v = 32'h028B0D43;
      5:  v = 32'h0145D7E1;
      6:  v = 32'h00A2F61E;
      7:  v = 32'h00517C55;
      8:  v = 32'h0028BE53;
      9:  v = 32'h00145F2F;
      10: v = 32'h000A2F98;
      11: v = 32'h000517CC;
      12: v = 32'h00028BE6;
      13: v = 32'h000145F3;
      14: v = 32'h0000A2F9;
      15: v = 32'h0000517D;
      16: v = 32'h000028BE;
      17: v = 32'h0000145F;
      18: v = 32'h00000A30;
      19: v = 32'h00000518;
      20: v = 32'h0000028C;
      21: v = 32'h00000146;
      22: v = 32'h000000A3;
      23: v = 32'h00000051;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/svg_front.sv
module svg_front import svg_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              psel_i,
  input  logic              penable_i,
  input  logic              pwrite_i,
  input  logic [ADDR_W-1:0] paddr_i,
  input  logic [31:0]       pwdata_i,
  input  logic [IDX_W-1:0]  stack_index_i,
  input  logic [IDX_W-1:0]  sector_index_i,
  input  logic              queue_full_i,
  output logic              push_o,
  output req_t              req_o,
  output logic [15:0]       radius_o,
  output logic [31:0]       prdata_o
);

  logic [15:0]      radius_q;
  logic [7:0]       sectors_q;
  logic [7:0]       stacks_q;
  logic             wr_en;
  reg_idx_e         wr_idx;
  logic [CNT_W-1:0] n_eff;
  logic [CNT_W-1:0] m_eff;

  function automatic logic [CNT_W-1:0] eff_count(input logic [7:0] c);
    logic [CNT_W-1:0] r;
    if (c == 8'd0) begin
      r = CNT_W'(1);
    end else if (int'(c) > MAX_COUNT) begin
      r = CNT_W'(MAX_COUNT);
    end else begin
      r = CNT_W'(c);
    end
    return r;
  endfunction

  assign wr_en  = psel_i & penable_i & pwrite_i;
  assign wr_idx = reg_idx_e'(paddr_i[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q  <= 16'd256;
      sectors_q <= 8'd36;
      stacks_q  <= 8'd18;
    end else if (wr_en) begin
      case (wr_idx)
        REG_RADIUS:  radius_q  <= pwdata_i[15:0];
        REG_SECTORS: sectors_q <= pwdata_i[7:0];
        REG_STACKS:  stacks_q  <= pwdata_i[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (wr_idx)
      REG_RADIUS:  prdata_o = {16'd0, radius_q};
      REG_SECTORS: prdata_o = {24'd0, sectors_q};
      REG_STACKS:  prdata_o = {24'd0, stacks_q};
      default:     prdata_o = 32'd0;
    endcase
  end

  assign n_eff    = eff_count(stacks_q);
  assign m_eff    = eff_count(sectors_q);
  assign radius_o = radius_q;
  assign push_o   = start_i & ~queue_full_i;

  always_comb begin
    req_o.stk = stack_index_i;
    req_o.sec = sector_index_i;
    req_o.n   = n_eff;
    req_o.m   = m_eff;
    req_o.oor = (stack_index_i > n_eff) || (sector_index_i > m_eff);
  end

endmodule

// File: rtl/svg_queue.sv
module svg_queue import svg_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  req_t data_i,
  input  logic pop_i,
  output req_t data_o,
  output logic full_o,
  output logic empty_o
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  req_t             mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [PTR_W:0]   count_q;

  assign full_o  = (count_q == (PTR_W+1)'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      count_q <= count_q + (PTR_W+1)'(push_i) - (PTR_W+1)'(pop_i);
    end
  end

endmodule

// File: rtl/svg_div.sv
module svg_div import svg_pkg::*; (
  input  logic             clk_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [CNT_W-1:0] den_i,
  output logic [QUO_W-1:0] quo_o
);

  logic [CNT_W-1:0] rem_q [QUO_W];
  logic [NUM_W-1:0] num_q [QUO_W];
  logic [CNT_W-1:0] den_q [QUO_W];
  logic [QUO_W-1:0] quo_q [QUO_W];

  // returns {quotient bit, new remainder}
  function automatic logic [CNT_W:0] div_step(input logic [CNT_W-1:0] rem,
                                             input logic b,
                                             input logic [CNT_W-1:0] den);
    logic [CNT_W:0] trial;
    logic [CNT_W:0] r;
    trial = {rem, b};
    if (trial >= {1'b0, den}) begin
      r = {1'b1, CNT_W'(trial - {1'b0, den})};
    end else begin
      r = {1'b0, trial[CNT_W-1:0]};
    end
    return r;
  endfunction

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    logic [CNT_W-1:0] rem_in;
    logic [NUM_W-1:0] num_in;
    logic [CNT_W-1:0] den_in;
    logic [QUO_W-1:0] quo_in;
    logic [CNT_W:0]   st;
    if (k == 0) begin : g_first
      assign rem_in = {1'b0, num_i[NUM_W-1:QUO_W]};
      assign num_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign num_in = num_q[k-1];
      assign den_in = den_q[k-1];
      assign quo_in = quo_q[k-1];
    end
    assign st = div_step(rem_in, num_in[QUO_W-1-k], den_in);
    always_ff @(posedge clk_i) begin
      rem_q[k] <= st[CNT_W-1:0];
      num_q[k] <= num_in;
      den_q[k] <= den_in;
      quo_q[k] <= {quo_in[QUO_W-2:0], st[CNT_W]};
    end
  end

  assign quo_o = quo_q[QUO_W-1];

endmodule

// File: rtl/svg_cordic.sv
module svg_cordic import svg_pkg::*; (
  input  logic                    clk_i,
  input  logic        [PH_W-1:0]  phase_i,
  output logic signed [Q14_W-1:0] cos_o,
  output logic signed [Q14_W-1:0] sin_o
);

  localparam logic signed [CORD_W-1:0] QUARTER = CORD_W'(64'sd1073741824);
  localparam logic signed [CORD_W-1:0] HALF    = CORD_W'(64'sd2147483648);

  logic signed [CORD_W-1:0] x_q [TRIG_ITERATIONS+1];
  logic signed [CORD_W-1:0] y_q [TRIG_ITERATIONS+1];
  logic signed [CORD_W-1:0] z_q [TRIG_ITERATIONS+1];
  logic                     neg_q [TRIG_ITERATIONS+1];

  logic signed [31:0]       z_raw;
  logic signed [CORD_W-1:0] z_ext;
  logic signed [CORD_W-1:0] z_fold;
  logic                     neg_fold;
  logic signed [CORD_W-1:0] x_fin, y_fin;

  function automatic logic signed [Q14_W-1:0] to_q14(input logic signed [CORD_W-1:0] v);
    logic signed [CORD_W-1:0] t;
    logic signed [Q14_W-1:0]  r;
    t = (v + CORD_W'(32768)) >>> 16;
    if (t > CORD_W'(16384)) begin
      r = Q14_W'(16384);
    end else if (t < -CORD_W'(16384)) begin
      r = -Q14_W'(16384);
    end else begin
      r = t[Q14_W-1:0];
    end
    return r;
  endfunction

  // fold into [-quarter, +quarter], a half turn flips the sign of both results
  assign z_raw = {phase_i, 16'h0000};
  assign z_ext = CORD_W'(z_raw);
  always_comb begin
    z_fold   = z_ext;
    neg_fold = 1'b0;
    if (z_ext > QUARTER) begin
      z_fold   = z_ext - HALF;
      neg_fold = 1'b1;
    end else if (z_ext < -QUARTER) begin
      z_fold   = z_ext + HALF;
      neg_fold = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q[0]   <= CORD_W'(CORDIC_START);
    y_q[0]   <= '0;
    z_q[0]   <= z_fold;
    neg_q[0] <= neg_fold;
  end

  for (genvar k = 1; k <= TRIG_ITERATIONS; k++) begin : g_iter
    localparam logic signed [CORD_W-1:0] ANG = CORD_W'(atan_lut(k - 1));
    always_ff @(posedge clk_i) begin
      neg_q[k] <= neg_q[k-1];
      if (z_q[k-1] >= 0) begin
        x_q[k] <= x_q[k-1] - (y_q[k-1] >>> (k - 1));
        y_q[k] <= y_q[k-1] + (x_q[k-1] >>> (k - 1));
        z_q[k] <= z_q[k-1] - ANG;
      end else begin
        x_q[k] <= x_q[k-1] + (y_q[k-1] >>> (k - 1));
        y_q[k] <= y_q[k-1] - (x_q[k-1] >>> (k - 1));
        z_q[k] <= z_q[k-1] + ANG;
      end
    end
  end

  assign x_fin = neg_q[TRIG_ITERATIONS] ? -x_q[TRIG_ITERATIONS] : x_q[TRIG_ITERATIONS];
  assign y_fin = neg_q[TRIG_ITERATIONS] ? -y_q[TRIG_ITERATIONS] : y_q[TRIG_ITERATIONS];

  always_ff @(posedge clk_i) begin
    cos_o <= to_q14(x_fin);
    sin_o <= to_q14(y_fin);
  end

endmodule

// File: rtl/svg_back.sv
module svg_back import svg_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    head_valid_i,
  input  req_t                    head_i,
  input  logic [15:0]             radius_i,
  output logic                    pop_o,
  output logic                    valid_o,
  output logic signed [16:0]      pos_x_o,
  output logic signed [16:0]      pos_y_o,
  output logic signed [16:0]      pos_z_o,
  output logic [16:0]             tex_s_o,
  output logic [16:0]             tex_t_o,
  output logic signed [Q14_W-1:0] norm_x_o,
  output logic signed [Q14_W-1:0] norm_y_o,
  output logic signed [Q14_W-1:0] norm_z_o,
  output logic                    oor_o
);

  typedef struct packed {
    logic             oor;
    logic [QUO_W-1:0] ts;
    logic [QUO_W-1:0] tt;
  } side_t;

  logic [NUM_W-1:0] num_off, num_tt, num_ts;
  logic [QUO_W-1:0] off, tt, ts;
  logic [PH_W-1:0]  ph_u, ph_v;

  logic             dv_q  [QUO_W];
  logic             doo_q [QUO_W];
  logic             cv_q  [CORDIC_LAT];
  side_t            cs_q  [CORDIC_LAT];
  side_t            side_div;

  logic signed [Q14_W-1:0] cu, su, cv, sv;

  logic               m1_v_q, m2_v_q;
  side_t              m1_s_q, m2_s_q;
  logic signed [31:0] cucv_q, cusv_q;
  logic signed [32:0] rcu_q, rsu_q;
  logic signed [Q14_W-1:0] cv1_q, sv1_q, su1_q;
  logic signed [Q14_W-1:0] nx_q, ny_q, nz_q;
  logic signed [48:0] px_q, py_q;
  logic signed [16:0] pz_q;
  logic signed [48:0] px_r, py_r;

  assign pop_o = head_valid_i;

  assign num_off = NUM_W'({head_i.stk, 15'd0}) + NUM_W'(head_i.n >> 1);
  assign num_tt  = NUM_W'({head_i.stk, 16'd0}) + NUM_W'(head_i.n >> 1);
  assign num_ts  = NUM_W'({head_i.sec, 16'd0}) + NUM_W'(head_i.m >> 1);

  svg_div u_div_off (.clk_i, .num_i(num_off), .den_i(head_i.n), .quo_o(off));
  svg_div u_div_tt  (.clk_i, .num_i(num_tt),  .den_i(head_i.n), .quo_o(tt));
  svg_div u_div_ts  (.clk_i, .num_i(num_ts),  .den_i(head_i.m), .quo_o(ts));

  // sideband alongside the dividers
  for (genvar k = 0; k < QUO_W; k++) begin : g_dline
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[k] <= 1'b0;
      end else begin
        dv_q[k] <= (k == 0) ? head_valid_i : dv_q[(k == 0) ? 0 : k-1];
      end
    end
    always_ff @(posedge clk_i) begin
      doo_q[k] <= (k == 0) ? head_i.oor : doo_q[(k == 0) ? 0 : k-1];
    end
  end

  assign ph_u = PH_W'(16384) - off[PH_W-1:0];
  assign ph_v = ts[PH_W-1:0];

  svg_cordic u_cordic_u (.clk_i, .phase_i(ph_u), .cos_o(cu), .sin_o(su));
  svg_cordic u_cordic_v (.clk_i, .phase_i(ph_v), .cos_o(cv), .sin_o(sv));

  assign side_div = '{oor: doo_q[QUO_W-1], ts: ts, tt: tt};

  for (genvar k = 0; k < CORDIC_LAT; k++) begin : g_cline
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cv_q[k] <= 1'b0;
      end else begin
        cv_q[k] <= (k == 0) ? dv_q[QUO_W-1] : cv_q[(k == 0) ? 0 : k-1];
      end
    end
    always_ff @(posedge clk_i) begin
      cs_q[k] <= (k == 0) ? side_div : cs_q[(k == 0) ? 0 : k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_v_q  <= 1'b0;
      m2_v_q  <= 1'b0;
      valid_o <= 1'b0;
    end else begin
      m1_v_q  <= cv_q[CORDIC_LAT-1];
      m2_v_q  <= m1_v_q;
      valid_o <= m2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    m1_s_q <= cs_q[CORDIC_LAT-1];
    cucv_q <= cu * cv;
    cusv_q <= cu * sv;
    rcu_q  <= $signed({1'b0, radius_i}) * cu;
    rsu_q  <= $signed({1'b0, radius_i}) * su;
    cv1_q  <= cv;
    sv1_q  <= sv;
    su1_q  <= su;
  end

  always_ff @(posedge clk_i) begin
    m2_s_q <= m1_s_q;
    nx_q   <= Q14_W'((cucv_q + 32'sd8192) >>> 14);
    ny_q   <= Q14_W'((cusv_q + 32'sd8192) >>> 14);
    nz_q   <= su1_q;
    px_q   <= rcu_q * cv1_q;
    py_q   <= rcu_q * sv1_q;
    pz_q   <= 17'((rsu_q + 33'sd8192) >>> 14);
  end

  assign px_r = (px_q + 49'sh8000000) >>> 28;
  assign py_r = (py_q + 49'sh8000000) >>> 28;

  always_ff @(posedge clk_i) begin
    oor_o <= m2_s_q.oor;
    if (m2_s_q.oor) begin
      pos_x_o  <= '0;
      pos_y_o  <= '0;
      pos_z_o  <= '0;
      tex_s_o  <= '0;
      tex_t_o  <= '0;
      norm_x_o <= '0;
      norm_y_o <= '0;
      norm_z_o <= '0;
    end else begin
      pos_x_o  <= px_r[16:0];
      pos_y_o  <= py_r[16:0];
      pos_z_o  <= pz_q;
      tex_s_o  <= m2_s_q.ts;
      tex_t_o  <= m2_s_q.tt;
      norm_x_o <= nx_q;
      norm_y_o <= ny_q;
      norm_z_o <= nz_q;
    end
  end

endmodule

// File: rtl/sphere_vertex_generator_core.sv
// channel    | direction | handshake                 | payload
// -----------+-----------+---------------------------+---------------------------------
// request    | in        | start, busy               | stack_index_i, sector_index_i
// result     | out       | result_valid_o (strobe)   | pos_*, tex_*, norm_*, out_of_range
// config     | in/out    | psel, penable, pwrite     | paddr, pwdata, prdata, pready
//
// one request per cycle; each one passes from the accepting edge through the queue, the
// 17-stage divider, the 18-stage cordic and 3 multiply stages to the result strobe
// reset: asynchronous, active low; registers return to radius 256, 36 sectors, 18 stacks
// the arithmetic pipeline never stalls since results cannot be held off, so the
// request queue drains every cycle and busy only rises if the queue is full
module sphere_vertex_generator_core import svg_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // request channel
  input  logic                    start,
  output logic                    busy,
  input  logic [IDX_W-1:0]        stack_index_i,
  input  logic [IDX_W-1:0]        sector_index_i,
  // config port
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [ADDR_W-1:0]       paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  // result channel
  output logic                    result_valid_o,
  output logic signed [16:0]      pos_x_o,
  output logic signed [16:0]      pos_y_o,
  output logic signed [16:0]      pos_z_o,
  output logic [16:0]             tex_s_o,
  output logic [16:0]             tex_t_o,
  output logic signed [Q14_W-1:0] norm_x_o,
  output logic signed [Q14_W-1:0] norm_y_o,
  output logic signed [Q14_W-1:0] norm_z_o,
  output logic                    out_of_range_o
);

  logic        push, pop, q_full, q_empty;
  req_t        req, head;
  logic [15:0] radius;

  assign pready = 1'b1;
  assign busy   = q_full;

  // front: register file, count clamping and range check
  svg_front u_front (
    .clk_i, .rst_ni,
    .start_i        (start),
    .psel_i         (psel),
    .penable_i      (penable),
    .pwrite_i       (pwrite),
    .paddr_i        (paddr),
    .pwdata_i       (pwdata),
    .stack_index_i,
    .sector_index_i,
    .queue_full_i   (q_full),
    .push_o         (push),
    .req_o          (req),
    .radius_o       (radius),
    .prdata_o       (prdata)
  );

  // short queue decoupling the front from the arithmetic pipeline
  svg_queue u_queue (
    .clk_i, .rst_ni,
    .push_i  (push),
    .data_i  (req),
    .pop_i   (pop),
    .data_o  (head),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // back: dividers for phase and tex coords, two cordics, multiply stages
  svg_back u_back (
    .clk_i, .rst_ni,
    .head_valid_i (~q_empty),
    .head_i       (head),
    .radius_i     (radius),
    .pop_o        (pop),
    .valid_o      (result_valid_o),
    .pos_x_o, .pos_y_o, .pos_z_o,
    .tex_s_o, .tex_t_o,
    .norm_x_o, .norm_y_o, .norm_z_o,
    .oor_o        (out_of_range_o)
  );

`ifndef ASSERT_OFF
  // queue is drained every cycle, so it never fills
  assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("request queue filled up");
  // an out-of-range request carries all-zero payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && out_of_range_o) |->
      (pos_x_o == '0 && pos_z_o == '0 && tex_s_o == '0 && tex_t_o == '0 && norm_z_o == '0))
    else $error("out-of-range result with nonzero payload");
  // tex coords never pass 1.0
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !out_of_range_o) |-> (tex_s_o <= 17'd65536 && tex_t_o <= 17'd65536))
    else $error("tex coordinate above one");
`endif

endmodule

// File: dv/sphere_vertex_generator_core_tb.sv
`timescale 1ns / 100ps

module sphere_vertex_generator_core_tb;
  import svg_pkg::*;

  // full turn of the widened phase and its fractions
  localparam longint PH_QUARTER = 64'd1073741824;
  localparam longint PH_HALF    = 64'd2147483648;
  localparam longint PH_FULL    = 64'd4294967296;
  localparam int     PIPE_WAIT  = 45;    // a little over the pipeline latency
  localparam int     WDOG_LIMIT = 4000;  // cycles without any request or result
  localparam int     PHASE_REQS = 225;
  localparam logic [ADDR_W-1:0] ADDR_SPARE = 4'd12;  // beyond the register file

  // arctangents of 2^-i, a full turn is 2^32
  localparam longint ATAN_TURNS [24] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
    64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2F9, 64'h0000517D, 64'h000028BE, 64'h0000145F,
    64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
  };

  typedef struct packed {
    logic [16:0] pos_x;
    logic [16:0] pos_y;
    logic [16:0] pos_z;
    logic [16:0] tex_s;
    logic [16:0] tex_t;
    logic [15:0] norm_x;
    logic [15:0] norm_y;
    logic [15:0] norm_z;
    logic        oor;
  } vertex_t;

  // directed row: indices, and a typed vertex where it is obvious
  typedef struct {
    logic [7:0] stk;
    logic [7:0] sec;
    bit         typed;
    vertex_t    vtx;
  } grid_row_t;

  localparam vertex_t OOR_VTX = '{oor: 1'b1, default: '0};

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  logic [IDX_W-1:0]        stack_index_i = '0;
  logic [IDX_W-1:0]        sector_index_i = '0;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [ADDR_W-1:0]       paddr = '0;
  logic [31:0]             pwdata = '0;
  logic [31:0]             prdata;
  logic                    pready;
  logic                    result_valid_o;
  logic signed [16:0]      pos_x_o, pos_y_o, pos_z_o;
  logic [16:0]             tex_s_o, tex_t_o;
  logic signed [Q14_W-1:0] norm_x_o, norm_y_o, norm_z_o;
  logic                    out_of_range_o;

  sphere_vertex_generator_core i_dut (
    .clk_i, .rst_ni, .start, .busy, .stack_index_i, .sector_index_i,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .result_valid_o, .pos_x_o, .pos_y_o, .pos_z_o, .tex_s_o, .tex_t_o,
    .norm_x_o, .norm_y_o, .norm_z_o, .out_of_range_o
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // predictor copy of the register file
  logic [15:0] sphere_radius = 16'd256;
  logic [7:0]  sector_cnt = 8'd36;
  logic [7:0]  stack_cnt = 8'd18;

  vertex_t pending_vertices[$];
  int      mismatches = 0;
  int      sent_reqs = 0;
  bit      gaps_on = 1'b1;
  int      quiet_cycles = 0;

  function automatic longint to_q14(input longint v);
    longint r;
    r = (v + 32768) >>> 16;
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    return r;
  endfunction

  // rotation-mode cordic on a 16 bit phase, results in Q1.14
  function automatic void cos_sin(input logic [15:0] ph, output longint c, output longint s);
    longint z, x, y, t;
    bit flip;
    z = longint'(ph) * 65536;
    x = longint'(CORDIC_START);
    y = 0;
    flip = 1'b0;
    if (z >= PH_HALF) z -= PH_FULL;
    // fold into the right half plane, negating the vector
    if (z > PH_QUARTER) begin
      z -= PH_HALF;
      flip = 1'b1;
    end else if (z < -PH_QUARTER) begin
      z += PH_HALF;
      flip = 1'b1;
    end
    for (int i = 0; i < TRIG_ITERATIONS && i < 24; i++) begin
      if (z >= 0) begin
        t = x - (y >>> i);
        y = y + (x >>> i);
        z -= ATAN_TURNS[i];
      end else begin
        t = x + (y >>> i);
        y = y - (x >>> i);
        z += ATAN_TURNS[i];
      end
      x = t;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = to_q14(x);
    s = to_q14(y);
  endfunction

  function automatic vertex_t grid_vertex(input logic [7:0] stk, input logic [7:0] sec);
    vertex_t v;
    longint n, m, off, ts, tt, cu, su, cv, sv, rad;
    n = (stack_cnt == 0) ? 1 : stack_cnt;
    m = (sector_cnt == 0) ? 1 : sector_cnt;
    rad = sphere_radius;
    if (stk > n || sec > m) return OOR_VTX;
    off = (longint'(stk) * 32768 + n / 2) / n;
    ts = (longint'(sec) * 65536 + m / 2) / m;
    tt = (longint'(stk) * 65536 + n / 2) / n;
    cos_sin(16'(16384 - off), cu, su);
    cos_sin(16'(ts), cv, sv);
    v.pos_x  = 17'((rad * cu * cv + (64'sd1 << 27)) >>> 28);
    v.pos_y  = 17'((rad * cu * sv + (64'sd1 << 27)) >>> 28);
    v.pos_z  = 17'((rad * su + 8192) >>> 14);
    v.tex_s  = 17'(ts);
    v.tex_t  = 17'(tt);
    v.norm_x = 16'((cu * cv + 8192) >>> 14);
    v.norm_y = 16'((cu * sv + 8192) >>> 14);
    v.norm_z = 16'(su);
    v.oor    = 1'b0;
    return v;
  endfunction

  // request and result monitor, samples pre-edge values
  always @(posedge clk_i) begin
    vertex_t got, want;
    if (rst_ni) begin
      if ((start && !busy) || result_valid_o) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (result_valid_o) begin
        got = '{pos_x_o, pos_y_o, pos_z_o, tex_s_o, tex_t_o,
                norm_x_o, norm_y_o, norm_z_o, out_of_range_o};
        if (pending_vertices.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", got);
        end else begin
          want = pending_vertices.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch\n  exp %p\n  got %p", want, got);
          end
        end
      end
      if (quiet_cycles >= WDOG_LIMIT) begin
        $display("[sphere_vertex_generator_core] ERROR");
        $finish;
      end
    end
  end

  // drives one request and returns once it has been taken
  task automatic send_request(input logic [7:0] stk, input logic [7:0] sec, input bit typed,
                              input vertex_t vtx);
    bit taken;
    while (gaps_on && $urandom_range(99) < 29) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start          <= 1'b1;
    stack_index_i  <= stk;
    sector_index_i <= sec;
    // expectation is queued before the accepting edge, results come much later
    pending_vertices = {pending_vertices, (typed ? vtx : grid_vertex(stk, sec))};
    do begin
      @(negedge clk_i);
      taken = !busy;
      @(posedge clk_i);
    end while (!taken);
    sent_reqs++;
  endtask

  task automatic drain_pipe();
    start <= 1'b0;
    while (pending_vertices.size() != 0) @(posedge clk_i);
    repeat (PIPE_WAIT) @(posedge clk_i);
  endtask

  // apb write: setup then access, register taken at the access edge
  task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (addr)
      {REG_RADIUS, 2'b00}:  sphere_radius = data[15:0];
      {REG_SECTORS, 2'b00}: sector_cnt = data[7:0];
      {REG_STACKS, 2'b00}:  stack_cnt = data[7:0];
      default: ;  // unmapped addresses are ignored
    endcase
  endtask

  task automatic set_sphere(input logic [31:0] rad, input logic [31:0] secs,
                            input logic [31:0] stks);
    write_reg({REG_RADIUS, 2'b00}, rad);
    write_reg({REG_SECTORS, 2'b00}, secs);
    write_reg({REG_STACKS, 2'b00}, stks);
  endtask

  // mostly grid points inside the current counts, some raw indices
  task automatic random_phase();
    int n, m;
    logic [7:0] stk, sec;
    n = (stack_cnt == 0) ? 1 : stack_cnt;
    m = (sector_cnt == 0) ? 1 : sector_cnt;
    for (int i = 0; i < PHASE_REQS; i++) begin
      if ($urandom_range(99) < 85) begin
        stk = $urandom_range(n);
        sec = $urandom_range(m);
      end else begin
        stk = $urandom_range(255);
        sec = $urandom_range(255);
      end
      send_request(stk, sec, 1'b0, OOR_VTX);
    end
    drain_pipe();
  endtask

  grid_row_t grid_rows[$] = '{
    '{8'd0,   8'd0,   1'b0, OOR_VTX},  // north pole
    '{8'd18,  8'd0,   1'b0, OOR_VTX},  // south pole
    '{8'd9,   8'd0,   1'b0, OOR_VTX},  // equator, each quadrant
    '{8'd9,   8'd9,   1'b0, OOR_VTX},
    '{8'd9,   8'd18,  1'b0, OOR_VTX},
    '{8'd9,   8'd27,  1'b0, OOR_VTX},
    '{8'd9,   8'd36,  1'b0, OOR_VTX},  // seam, sector equal to count
    '{8'd18,  8'd36,  1'b0, OOR_VTX},
    '{8'd4,   8'd31,  1'b0, OOR_VTX},
    '{8'd13,  8'd5,   1'b0, OOR_VTX},
    '{8'd19,  8'd0,   1'b1, OOR_VTX},  // stack beyond count
    '{8'd0,   8'd37,  1'b1, OOR_VTX},  // sector beyond count
    '{8'd255, 8'd255, 1'b1, OOR_VTX},
    '{8'd170, 8'd85,  1'b1, OOR_VTX},
    '{8'd85,  8'd170, 1'b1, OOR_VTX},
    '{8'd1,   8'd35,  1'b0, OOR_VTX}
  };

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset register values
    foreach (grid_rows[i]) send_request(grid_rows[i].stk, grid_rows[i].sec,
                                        grid_rows[i].typed, grid_rows[i].vtx);
    drain_pipe();

    // smallest sphere, plus a write to an unmapped address
    set_sphere(32'd0, 32'd1, 32'd1);
    write_reg(ADDR_SPARE, 32'hFFFF_FFFF);
    random_phase();
    // largest sphere and densest grid
    set_sphere(32'hFFFF, 32'd255, 32'd255);
    random_phase();
    // upper data bits dropped, zero counts act as one
    set_sphere(32'hFFFF_1234, 32'hFFFF_FF00, 32'h0000_FF00);
    random_phase();
    // back-to-back requests with no gaps
    gaps_on = 1'b0;
    set_sphere($urandom_range(65535), $urandom_range(255, 1), $urandom_range(20, 1));
    random_phase();
    gaps_on = 1'b1;
    set_sphere($urandom_range(65535), $urandom_range(12, 1), $urandom_range(255, 1));
    random_phase();
    set_sphere(32'd256, 32'd36, 32'd18);
    random_phase();

    if (mismatches == 0 && pending_vertices.size() == 0) begin
      $display("[sphere_vertex_generator_core] OK");
    end else begin
      $display("[sphere_vertex_generator_core] ERROR");
    end
    $finish;
  end

endmodule
